### hdl/ec_point_scalar_multiply_assert.svh
// Assertion macros shared by the RTL; they expect clk and rst in scope.
`ifndef EC_POINT_SCALAR_MULTIPLY_ASSERT_SVH
`define EC_POINT_SCALAR_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define ECSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecsm assertion failed");

// Next-cycle implication.
`define ECSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecsm assertion failed");

`endif

### hdl/ecsm_pkg.sv
`default_nettype none
package ecsm_pkg;

  localparam int FIELD_BITS = 64;
  localparam int CNT_W      = $clog2(FIELD_BITS);
  localparam int IN_W       = 328;
  localparam int OUT_W      = 136;
  localparam int CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 8'd1;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_MUL = 1'b1;

  typedef logic [FIELD_BITS-1:0] fword_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  // Operands below m.
  function automatic fword_t mod_add(fword_t x, fword_t y, fword_t m);
    logic [FIELD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[FIELD_BITS-1:0];
  endfunction

  function automatic fword_t mod_sub(fword_t x, fword_t y, fword_t m);
    fword_t d;
    d = x - y;
    if (x < y) begin
      d = d + m;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

### hdl/ec_point_scalar_multiply.sv
`default_nettype none
// Elliptic-curve point unit over a prime field, short Weierstrass curve, affine
// coordinates. An item with kind 0 returns P + Q; kind 1 returns scalar * P by
// right-to-left double-and-add. Every item gives exactly one result item. All
// field arithmetic runs through one shared unit: modular add and subtract, a
// modular multiply by double-and-add over the multiplier bits, and a restoring
// divide. Each point addition needs one inversion by the extended Euclidean
// method with up to about 93 quotient steps, plus three multiplies for a chord
// or four for a tangent. The inputs and curve_a are first reduced modulo the
// modulus. A scalar multiply makes up to 127 point additions. s_tready is high
// only between items; a finished result waits in the output register while the
// next item is taken. Write modulus and curve_a only while the block is idle;
// a modulus below 3 acts as 3. A result at infinity reads zero coordinates.
module ec_point_scalar_multiply import ecsm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // scalar[63:0] p_x[127:64] p_y[191:128] p_infinite[192]
  // q_x[256:193] q_y[320:257] q_infinite[321] zero[327:322]
  input  wire logic [IN_W-1:0]      s_tdata,
  // kind[0]
  input  wire logic                 s_tuser,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // r_x[63:0] r_y[127:64] r_infinite[128] zero[135:129]
  output logic [OUT_W-1:0]          m_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  `include "ec_point_scalar_multiply_assert.svh"

  typedef enum logic [26:0] {
    S_IDLE  = 27'd1 << 0,
    S_RED   = 27'd1 << 1,
    S_DISP  = 27'd1 << 2,
    S_LOOP  = 27'd1 << 3,
    S_SHIFT = 27'd1 << 4,
    S_ADD   = 27'd1 << 5,
    S_D1    = 27'd1 << 6,
    S_D2    = 27'd1 << 7,
    S_D3    = 27'd1 << 8,
    S_D4    = 27'd1 << 9,
    S_D5    = 27'd1 << 10,
    S_C1    = 27'd1 << 11,
    S_C2    = 27'd1 << 12,
    S_IINIT = 27'd1 << 13,
    S_ITEST = 27'd1 << 14,
    S_IDIV  = 27'd1 << 15,
    S_IMUL  = 27'd1 << 16,
    S_ISUB  = 27'd1 << 17,
    S_LAM   = 27'd1 << 18,
    S_X1    = 27'd1 << 19,
    S_X2    = 27'd1 << 20,
    S_X3    = 27'd1 << 21,
    S_Y1    = 27'd1 << 22,
    S_Y2    = 27'd1 << 23,
    S_Y3    = 27'd1 << 24,
    S_ADONE = 27'd1 << 25,
    S_OUT   = 27'd1 << 26
  } state_t;

  // Where a finished point addition goes.
  typedef enum logic [1:0] {
    RET_TOP = 2'd0,
    RET_R   = 2'd1,
    RET_ACC = 2'd2
  } ret_t;

  state_t       state;
  ret_t         ret;
  logic         issued;
  logic [2:0]   red_idx;

  fword_t       modulus_reg;
  fword_t       curve_a_reg;
  fword_t       m_reg;
  fword_t       m_clamp;

  logic         kind;
  logic [63:0]  scalar;
  fword_t       a_red;
  fword_t       px, py, qx, qy;
  logic         pinf, qinf;
  fword_t       rx, ry, accx, accy, ux, uy, vx, vy, wx, wy;
  logic         rinf, accinf, uinf, vinf, winf;
  logic         dbl;
  fword_t       tmp, num, den, r0, r1, t0, t1, qm;

  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  fword_t       alu_a, alu_b, alu_res, alu_quo;
  logic         alu_use;

  fword_t       nqy;
  logic         x_eq, is_neg, is_same;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  assign m_clamp = (modulus_reg < fword_t'(3)) ? fword_t'(3) : modulus_reg;

  // Special-case checks for the point addition.
  assign nqy     = (vy == '0) ? '0 : m_reg - vy;
  assign x_eq    = (ux == vx);
  assign is_neg  = (uinf && vinf) || (!uinf && !vinf && x_eq && (uy == nqy));
  assign is_same = x_eq && (uy == vy);

  // Operand selection for the shared unit.
  always_comb begin
    alu_use = 1'b1;
    alu_req.op = ALU_ADD;
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      S_RED: begin
        alu_req.op = ALU_DIV;
        alu_b = m_reg;
        unique case (red_idx)
          3'd1:    alu_a = px;
          3'd2:    alu_a = py;
          3'd3:    alu_a = qx;
          3'd4:    alu_a = qy;
          default: alu_a = a_red;
        endcase
      end
      S_D1:   begin alu_req.op = ALU_MUL; alu_a = ux;  alu_b = ux;    end
      S_D2:   begin alu_req.op = ALU_ADD; alu_a = tmp; alu_b = tmp;   end
      S_D3:   begin alu_req.op = ALU_ADD; alu_a = num; alu_b = tmp;   end
      S_D4:   begin alu_req.op = ALU_ADD; alu_a = num; alu_b = a_red; end
      S_D5:   begin alu_req.op = ALU_ADD; alu_a = uy;  alu_b = uy;    end
      S_C1:   begin alu_req.op = ALU_SUB; alu_a = uy;  alu_b = vy;    end
      S_C2:   begin alu_req.op = ALU_SUB; alu_a = ux;  alu_b = vx;    end
      S_IDIV: begin alu_req.op = ALU_DIV; alu_a = r0;  alu_b = r1;    end
      S_IMUL: begin alu_req.op = ALU_MUL; alu_a = qm;  alu_b = t1;    end
      S_ISUB: begin alu_req.op = ALU_SUB; alu_a = t0;  alu_b = tmp;   end
      S_LAM:  begin alu_req.op = ALU_MUL; alu_a = num; alu_b = den;   end
      S_X1:   begin alu_req.op = ALU_MUL; alu_a = num; alu_b = num;   end
      S_X2: begin
        alu_req.op = ALU_ADD;
        alu_a = ux;
        alu_b = dbl ? ux : vx;
      end
      S_X3:   begin alu_req.op = ALU_SUB; alu_a = tmp; alu_b = den;   end
      S_Y1:   begin alu_req.op = ALU_SUB; alu_a = ux;  alu_b = wx;    end
      S_Y2:   begin alu_req.op = ALU_MUL; alu_a = num; alu_b = tmp;   end
      S_Y3:   begin alu_req.op = ALU_SUB; alu_a = tmp; alu_b = uy;    end
      default: alu_use = 1'b0;
    endcase
    alu_req.start = alu_use && !issued;
  end

  ecsm_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .opa (alu_a),
    .opb (alu_b),
    .m   (m_reg),
    .rsp (alu_rsp),
    .res (alu_res),
    .quo (alu_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      issued      <= 1'b0;
      m_tvalid    <= 1'b0;
      modulus_reg <= fword_t'(3);
      curve_a_reg <= fword_t'(1);
      m_reg       <= fword_t'(3);
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MODULUS) begin
          modulus_reg <= fword_t'(cfg_data);
        end else if (cfg_index == CFG_CURVE_A) begin
          curve_a_reg <= fword_t'(cfg_data);
        end
      end

      if (alu_req.start) begin
        issued <= 1'b1;
      end else if (alu_rsp.done) begin
        issued <= 1'b0;
      end

      // Drop the result once taken, unless S_OUT reloads it in this cycle.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind    <= s_tuser;
            scalar  <= s_tdata[63:0];
            px      <= fword_t'(s_tdata[127:64]);
            py      <= fword_t'(s_tdata[191:128]);
            pinf    <= s_tdata[192];
            qx      <= fword_t'(s_tdata[256:193]);
            qy      <= fword_t'(s_tdata[320:257]);
            qinf    <= s_tdata[321];
            a_red   <= curve_a_reg;
            m_reg   <= m_clamp;
            red_idx <= '0;
            state   <= S_RED;
          end
        end
        S_RED: begin
          if (alu_rsp.done) begin
            unique case (red_idx)
              3'd1:    px    <= alu_res;
              3'd2:    py    <= alu_res;
              3'd3:    qx    <= alu_res;
              3'd4:    qy    <= alu_res;
              default: a_red <= alu_res;
            endcase
            if (red_idx == 3'd4) begin
              state <= S_DISP;
            end else begin
              red_idx <= red_idx + 1'b1;
            end
          end
        end
        S_DISP: begin
          if (kind == KIND_ADD) begin
            ux <= px; uy <= py; uinf <= pinf;
            vx <= qx; vy <= qy; vinf <= qinf;
            ret   <= RET_TOP;
            state <= S_ADD;
          end else begin
            rx <= '0; ry <= '0; rinf <= 1'b1;
            accx <= px; accy <= py; accinf <= pinf;
            state <= pinf ? S_OUT : S_LOOP;
          end
        end
        S_LOOP: begin
          priority if (scalar == '0) begin
            state <= S_OUT;
          end else if (scalar[0]) begin
            ux <= rx;   uy <= ry;   uinf <= rinf;
            vx <= accx; vy <= accy; vinf <= accinf;
            ret   <= RET_R;
            state <= S_ADD;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          scalar <= scalar >> 1;
          if ((scalar >> 1) != '0) begin
            ux <= accx; uy <= accy; uinf <= accinf;
            vx <= accx; vy <= accy; vinf <= accinf;
            ret   <= RET_ACC;
            state <= S_ADD;
          end else begin
            state <= S_LOOP;
          end
        end
        S_ADD: begin
          priority if (is_neg) begin
            wx <= '0; wy <= '0; winf <= 1'b1;
            state <= S_ADONE;
          end else if (uinf) begin
            wx <= vx; wy <= vy; winf <= vinf;
            state <= S_ADONE;
          end else if (vinf) begin
            wx <= ux; wy <= uy; winf <= uinf;
            state <= S_ADONE;
          end else if (is_same) begin
            dbl   <= 1'b1;
            state <= S_D1;
          end else begin
            dbl   <= 1'b0;
            state <= S_C1;
          end
        end
        S_D1: if (alu_rsp.done) begin tmp <= alu_res; state <= S_D2;    end
        S_D2: if (alu_rsp.done) begin num <= alu_res; state <= S_D3;    end
        S_D3: if (alu_rsp.done) begin num <= alu_res; state <= S_D4;    end
        S_D4: if (alu_rsp.done) begin num <= alu_res; state <= S_D5;    end
        S_D5: if (alu_rsp.done) begin den <= alu_res; state <= S_IINIT; end
        S_C1: if (alu_rsp.done) begin num <= alu_res; state <= S_C2;    end
        S_C2: if (alu_rsp.done) begin den <= alu_res; state <= S_IINIT; end
        S_IINIT: begin
          r0 <= m_reg;
          r1 <= den;
          t0 <= '0;
          t1 <= fword_t'(1);
          state <= S_ITEST;
        end
        S_ITEST: begin
          if (r1 == '0) begin
            // No inverse unless the gcd is one; the slope is then zero.
            den   <= (r0 == fword_t'(1)) ? t0 : '0;
            state <= S_LAM;
          end else begin
            state <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (alu_rsp.done) begin
            r0    <= r1;
            r1    <= alu_res;
            qm    <= (alu_quo == m_reg) ? '0 : alu_quo;
            state <= S_IMUL;
          end
        end
        S_IMUL: if (alu_rsp.done) begin tmp <= alu_res; state <= S_ISUB; end
        S_ISUB: begin
          if (alu_rsp.done) begin
            t0    <= t1;
            t1    <= alu_res;
            state <= S_ITEST;
          end
        end
        S_LAM: if (alu_rsp.done) begin num <= alu_res; state <= S_X1; end
        S_X1:  if (alu_rsp.done) begin tmp <= alu_res; state <= S_X2; end
        S_X2:  if (alu_rsp.done) begin den <= alu_res; state <= S_X3; end
        S_X3:  if (alu_rsp.done) begin wx  <= alu_res; state <= S_Y1; end
        S_Y1:  if (alu_rsp.done) begin tmp <= alu_res; state <= S_Y2; end
        S_Y2:  if (alu_rsp.done) begin tmp <= alu_res; state <= S_Y3; end
        S_Y3: begin
          if (alu_rsp.done) begin
            wy    <= alu_res;
            winf  <= 1'b0;
            state <= S_ADONE;
          end
        end
        S_ADONE: begin
          unique case (ret)
            RET_R: begin
              rx <= wx; ry <= wy; rinf <= winf;
              state <= S_SHIFT;
            end
            RET_ACC: begin
              accx <= wx; accy <= wy; accinf <= winf;
              state <= S_LOOP;
            end
            default: begin
              rx <= wx; ry <= wy; rinf <= winf;
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          // Hold until the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tdata  <= rinf ? {{(OUT_W-1){1'b0}}, 1'b1} << 128
                             : {7'b0, 1'b0, 64'(ry), 64'(rx)};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ECSM_ASSERT_IMP(a_alu_start_idle, alu_req.start, !alu_rsp.busy && !issued)
  `ECSM_ASSERT_IMP(a_alu_done_issued, alu_rsp.done, issued)
  `ECSM_ASSERT_IMP(a_modulus_min, 1'b1, m_reg >= fword_t'(3))
  `ECSM_ASSERT_NEXT(a_inv_init, state == S_IINIT, state == S_ITEST && r0 == m_reg)

endmodule
`default_nettype wire

### hdl/ecsm_alu.sv
`default_nettype none
module ecsm_alu import ecsm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire alu_req_t req,
  input  wire fword_t   opa,
  input  wire fword_t   opb,
  input  wire fword_t   m,
  output alu_rsp_t      rsp,
  output fword_t        res,
  output fword_t        quo
);

  logic                busy;
  logic                done;
  logic                done_next;
  alu_op_t             op_r;
  fword_t              a_r;
  fword_t              b_r;
  fword_t              acc;
  fword_t              quo_r;
  logic [CNT_W-1:0]    cnt;
  logic                phase;
  logic [FIELD_BITS:0] div_sh;
  logic                div_ge;

  // Restoring division: shift in one dividend bit, subtract if it fits.
  assign div_sh = {acc, quo_r[FIELD_BITS-1]};
  assign div_ge = (div_sh >= {1'b0, b_r});

  // Flag completion: single-step ops at once, iterative ops on the last bit.
  always_comb begin
    done_next = 1'b0;
    if (req.start) begin
      done_next = (req.op == ALU_ADD) || (req.op == ALU_SUB);
    end else if (busy && cnt == '0) begin
      done_next = (op_r == ALU_DIV) || (op_r == ALU_MUL && phase);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= done_next;
      if (req.start) begin
        op_r  <= req.op;
        a_r   <= opa;
        b_r   <= opb;
        quo_r <= opa;
        cnt   <= CNT_W'(FIELD_BITS - 1);
        phase <= 1'b0;
        unique case (req.op)
          ALU_ADD: begin
            acc  <= mod_add(opa, opb, m);
          end
          ALU_SUB: begin
            acc  <= mod_sub(opa, opb, m);
          end
          ALU_MUL, ALU_DIV: begin
            acc  <= '0;
            busy <= 1'b1;
          end
        endcase
      end else if (busy) begin
        unique case (op_r)
          ALU_MUL: begin
            if (!phase) begin
              acc   <= mod_add(acc, acc, m);
              phase <= 1'b1;
            end else begin
              if (b_r[FIELD_BITS-1]) begin
                acc <= mod_add(acc, a_r, m);
              end
              b_r   <= b_r << 1;
              phase <= 1'b0;
              if (cnt == '0) begin
                busy <= 1'b0;
              end else begin
                cnt <= cnt - 1'b1;
              end
            end
          end
          ALU_DIV: begin
            quo_r <= {quo_r[FIELD_BITS-2:0], div_ge};
            acc   <= div_ge ? fword_t'(div_sh - {1'b0, b_r}) : fword_t'(div_sh);
            if (cnt == '0) begin
              busy <= 1'b0;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign res      = acc;
  assign quo      = quo_r;

endmodule
`default_nettype wire
